// ----- sv/sbks_pkg.sv -----
// ---------------------------------------------------------------------------
// Scanline background key strip: shared package
// Widths, payload and command types, register indexes and the channel
// match helper used by the front and back parts of the block.
// ---------------------------------------------------------------------------
package sbks_pkg;

   // Line store geometry.
   localparam int MAX_WIDTH = 1024;
   localparam int POS_W     = $clog2(MAX_WIDTH);
   localparam int ADDR_W    = POS_W + 1;
   localparam int WIDTH_W   = 11;
   localparam int THRESH_W  = 9;
   localparam int COL_W     = 10;
   localparam int PIX_W     = 24;

   // Register indexes on the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND_COLUMN = 2'd2;

   // Register reset values.
   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RESET = 11'd512;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 9'd1;
   localparam logic [COL_W-1:0]    BG_COLUMN_RESET  = 10'd0;

   // Item mode codes.
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } sbks_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       matched;
      logic       last_of_line;
   } sbks_rsp_type;

   // One emission command from the front to the back.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] key;
      logic             last;
   } sbks_cmd_type;

   // Register values seen by the front part.
   typedef struct packed {
      logic [WIDTH_W-1:0] line_width;
      logic [COL_W-1:0]   background_column;
   } sbks_front_cfg_type;

   // True when the two channel values differ by strictly less than the bound.
   function automatic logic chan_close(input logic [7:0] a, input logic [7:0] b,
                                       input logic [THRESH_W-1:0] bound);
      logic [7:0] diff;
      diff = (a >= b) ? (a - b) : (b - a);
      return ({1'b0, diff} < bound);
   endfunction

endpackage

// ----- sv/sbks_front.sv -----
// ---------------------------------------------------------------------------
// Scanline background key strip: front part
// Accepts items, keeps the line position state and the two-bank line
// store, reads the held pixel and hands emission commands to the queue.
// ---------------------------------------------------------------------------
module sbks_front (
   input  logic                        clock,
   input  logic                        reset,
   input  sbks_pkg::sbks_front_cfg_type cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sbks_pkg::sbks_req_type      req_data,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output sbks_pkg::sbks_cmd_type      cmd_data
);
   import sbks_pkg::*;

   logic [PIX_W-1:0]   mem [2*MAX_WIDTH];
   logic [PIX_W-1:0]   rdata_ff;

   logic [POS_W-1:0]   write_pos_ff, write_pos_in;
   logic [POS_W-1:0]   read_pos_ff, read_pos_in;
   logic               bank_ff, bank_in;
   logic [PIX_W-1:0]   filling_key_ff, filling_key_in;
   logic [PIX_W-1:0]   held_key_ff, held_key_in;
   logic               held_valid_ff, held_valid_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_key_ff;
   logic               s1_last_ff;

   logic [WIDTH_W-1:0] eff_width;
   logic [POS_W-1:0]   last_idx;
   logic [POS_W-1:0]   rd_pos;
   logic [POS_W-1:0]   wr_pos;
   logic [POS_W-1:0]   key_col;
   logic               rd_last;
   logic               line_done;
   logic               accept;
   logic               wr_en;
   logic [PIX_W-1:0]   in_pixel;

   // Effective width, clamped to 1..MAX_WIDTH, and its last index.
   always_comb begin
      if (cfg.line_width == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (cfg.line_width > WIDTH_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_width = cfg.line_width;
      end
   end
   assign last_idx = POS_W'(eff_width - WIDTH_W'(1));

   // Clamp positions and the key column to the line.
   assign rd_pos  = ({1'b0, read_pos_ff} >= eff_width) ? last_idx : read_pos_ff;
   assign wr_pos  = ({1'b0, write_pos_ff} >= eff_width) ? last_idx : write_pos_ff;
   assign key_col = (cfg.background_column > last_idx) ? last_idx : cfg.background_column;
   assign rd_last   = (rd_pos == last_idx);
   assign line_done = (wr_pos == last_idx);

   // Handshake: the read stage frees up whenever the queue takes its item.
   assign req_ready = !s1_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_data.mode == MODE_PIXEL);
   assign in_pixel  = {req_data.red_in, req_data.green_in, req_data.blue_in};

   // Next state for one accepted item: emission first, then the pixel write.
   always_comb begin
      write_pos_in   = write_pos_ff;
      read_pos_in    = read_pos_ff;
      bank_in        = bank_ff;
      filling_key_in = filling_key_ff;
      held_key_in    = held_key_ff;
      held_valid_in  = held_valid_ff;
      if (accept) begin
         if (held_valid_ff) begin
            if (rd_last) begin
               held_valid_in = 1'b0;
               read_pos_in   = '0;
            end else begin
               read_pos_in = rd_pos + POS_W'(1);
            end
         end
         if (req_data.mode == MODE_FLUSH) begin
            write_pos_in = '0;
         end else begin
            if (wr_pos == key_col) begin
               filling_key_in = in_pixel;
            end
            if (line_done) begin
               held_key_in   = filling_key_in;
               held_valid_in = 1'b1;
               read_pos_in   = '0;
               bank_in       = !bank_ff;
               write_pos_in  = '0;
            end else begin
               write_pos_in = wr_pos + POS_W'(1);
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff   <= '0;
         read_pos_ff    <= '0;
         bank_ff        <= 1'b0;
         filling_key_ff <= '0;
         held_key_ff    <= '0;
         held_valid_ff  <= 1'b0;
      end else begin
         write_pos_ff   <= write_pos_in;
         read_pos_ff    <= read_pos_in;
         bank_ff        <= bank_in;
         filling_key_ff <= filling_key_in;
         held_key_ff    <= held_key_in;
         held_valid_ff  <= held_valid_in;
      end
   end

   // Line store: write into the filling bank, read the held bank.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{bank_ff, wr_pos}] <= in_pixel;
      end
      if (accept) begin
         rdata_ff <= mem[{!bank_ff, rd_pos}];
      end
   end

   // Read stage: valid while an emission waits for room in the queue.
   always_comb begin
      if (accept) begin
         s1_valid_in = held_valid_ff;
      end else if (cmd_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff  <= held_key_ff;
         s1_last_ff <= rd_last;
      end
   end

   assign cmd_valid      = s1_valid_ff;
   assign cmd_data.pixel = rdata_ff;
   assign cmd_data.key   = s1_key_ff;
   assign cmd_data.last  = s1_last_ff;

endmodule

// ----- sv/sbks_queue.sv -----
// ---------------------------------------------------------------------------
// Scanline background key strip: command queue
// Two-entry queue between the front and back parts, push and pop in the
// same cycle allowed.
// ---------------------------------------------------------------------------
module sbks_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  sbks_pkg::sbks_cmd_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output sbks_pkg::sbks_cmd_type pop_data
);
   import sbks_pkg::*;

   sbks_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/sbks_back.sv -----
// ---------------------------------------------------------------------------
// Scanline background key strip: back part
// Compares each held pixel with its line key and registers the result
// item for the output channel.
// ---------------------------------------------------------------------------
module sbks_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sbks_pkg::THRESH_W-1:0]  threshold,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  sbks_pkg::sbks_cmd_type         cmd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sbks_pkg::sbks_rsp_type         rsp_data
);
   import sbks_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   sbks_rsp_type rsp_data_ff, rsp_data_in;
   logic         load;
   logic         match;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign load      = cmd_valid && cmd_ready;

   // All three channels must sit strictly inside the threshold.
   assign match = chan_close(cmd_data.pixel[23:16], cmd_data.key[23:16], threshold) &&
                  chan_close(cmd_data.pixel[15:8],  cmd_data.key[15:8],  threshold) &&
                  chan_close(cmd_data.pixel[7:0],   cmd_data.key[7:0],   threshold);

   always_comb begin
      rsp_data_in.red_out      = match ? 8'd0 : cmd_data.pixel[23:16];
      rsp_data_in.green_out    = match ? 8'd0 : cmd_data.pixel[15:8];
      rsp_data_in.blue_out     = match ? 8'd0 : cmd_data.pixel[7:0];
      rsp_data_in.matched      = match;
      rsp_data_in.last_of_line = cmd_data.last;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/scanline_background_key_strip.sv -----
// ---------------------------------------------------------------------------
// Scanline background key strip: top level
// Per-line background color keying over a raster pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  carries one item per pixel (mode 0) or a flush (mode 1). Pixels
//          fill one bank of a two-bank line store; the completed line is
//          emitted during the next line, one result item per input item.
//   rsp_*  carries the emitted pixel, blacked with matched set when all
//          three channels lie strictly within threshold of the line key.
//   csr_*  writes line_width (0), threshold (1) and background_column (2).
//          It is always ready; write only while the block is idle.
// Throughput is one item per clock while the receiver takes results. The
// line store takes one write and one read per cycle, which sets that rate.
// Results pass the read stage, the queue and the output register in turn.
// A stalled receiver fills the output register, the two-entry queue and the
// read stage; after that req_ready drops until results drain.
// Reset clears the positions, keys and held line and restores the register
// defaults; the line store contents are not cleared and need no pass.
// ---------------------------------------------------------------------------
module scanline_background_key_strip (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sbks_pkg::sbks_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sbks_pkg::sbks_rsp_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbks_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbks_pkg::WIDTH_W-1:0]    csr_data
);
   import sbks_pkg::*;

   logic [WIDTH_W-1:0]  line_width_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic [COL_W-1:0]    bg_column_ff;
   logic                csr_write;

   sbks_front_cfg_type  front_cfg;
   logic                cmd_valid;
   logic                cmd_ready;
   sbks_cmd_type        cmd_data;
   logic                q_valid;
   logic                q_ready;
   sbks_cmd_type        q_data;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         bg_column_ff  <= BG_COLUMN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_ff <= csr_data;
            end
            CSR_THRESHOLD: begin
               threshold_ff <= csr_data[THRESH_W-1:0];
            end
            CSR_BACKGROUND_COLUMN: begin
               bg_column_ff <= csr_data[COL_W-1:0];
            end
            default: begin
               line_width_ff <= line_width_ff;
            end
         endcase
      end
   end

   assign front_cfg.line_width        = line_width_ff;
   assign front_cfg.background_column = bg_column_ff;

   // Front part: accept, track lines, read the held pixel.
   sbks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (front_cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Queue between the two parts.
   sbks_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_data  (cmd_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // Back part: key compare and output register.
   sbks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
